[sv/sazoh_pkg.sv]
// Shared types and constants for the rate-limited steering actuator.
// Holds the configuration layout, controller command and status words,
// and the fixed-point constants. Depends on nothing.
package sazoh_pkg;

	localparam int WORD_W     = 32;
	localparam int LIM_W      = 31;
	localparam int OPND_W     = 33;
	localparam int PROD_W     = 2 * OPND_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FRAC_BITS_DEF = 24;

	localparam logic signed [WORD_W-1:0] ANGLE_MIN_CODE = -32'sd6710886;
	localparam logic signed [WORD_W-1:0] ANGLE_MAX_CODE = 32'sd6710886;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_A00   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A01   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_A10   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_A11   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_B0    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_B1    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd7;

	// Reset values of the configuration registers.
	localparam logic signed [WORD_W-1:0] RST_COEF_ONE  = 32'sd16777216;
	localparam logic signed [WORD_W-1:0] RST_COEF_ZERO = 32'sd0;
	localparam logic [LIM_W-1:0]         RST_LIMIT     = 31'd16777216;
	localparam logic [LIM_W-1:0]         RST_STEP      = 31'd167772;

	typedef struct packed {
		logic signed [WORD_W-1:0] a00;
		logic signed [WORD_W-1:0] a01;
		logic signed [WORD_W-1:0] a10;
		logic signed [WORD_W-1:0] a11;
		logic signed [WORD_W-1:0] b0;
		logic signed [WORD_W-1:0] b1;
		logic [LIM_W-1:0]         rate_limit;
		logic [LIM_W-1:0]         step_time;
	} cfg_t;

	typedef enum logic [1:0] {
		BR_EXACT   = 2'd0,
		BR_PINNED  = 2'd1,
		BR_MIDSTEP = 2'd2
	} br_t;

	// Operand pair presented to the shared multiplier.
	typedef enum logic [3:0] {
		MS_A00_ANG,
		MS_A01_RATE,
		MS_B0_REQ,
		MS_A10_ANG,
		MS_A11_RATE,
		MS_B1_REQ,
		MS_RATE_DT,
		MS_FRAC_DT,
		MS_OMF_DT,
		MS_SUM_TACC,
		MS_LIM_TCON
	} mul_sel_t;

	// What the datapath does with the registered product.
	typedef enum logic [3:0] {
		ACC_NONE,
		ACC_CLR,
		ACC_ROW_A,
		ACC_ROW_R,
		ACC_ANG_INIT,
		ACC_ANG_EXACT,
		ACC_ANG_PIN,
		ACC_ANG_DACC,
		ACC_ANG_DCON,
		ACC_CAP_TACC,
		ACC_CAP_TCON
	} acc_op_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     sat_en;
		logic     div_start;
		logic     br_en;
		br_t      br_val;
		logic     finish;
	} cmd_t;

	typedef struct packed {
		logic rate_ok;
		logic rate_sat;
		logic div_done;
		logic out_free;
	} sts_t;

	function automatic logic [OPND_W-1:0] sext33(input logic [WORD_W-1:0] v);
		return {v[WORD_W-1], v};
	endfunction

endpackage

[sv/sazoh_div.sv]
// Restoring divider, one quotient bit per cycle, for the mid-step fraction.
// Computes floor((num << FRAC_BITS) / den) for num < den.
// Depends on sazoh_pkg.
module sazoh_div #(
	parameter int FRAC_BITS = sazoh_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sazoh_pkg::OPND_W-1:0]      num,
	input  logic [sazoh_pkg::OPND_W-1:0]      den,
	output logic                              done,
	output logic [FRAC_BITS-1:0]              quo
);

	localparam int CNT_W = $clog2(FRAC_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [sazoh_pkg::OPND_W-1:0]  rem_q;
	logic [sazoh_pkg::OPND_W-1:0]  den_q;
	logic [FRAC_BITS-1:0]          quo_q;
	logic [sazoh_pkg::OPND_W:0]    trial;
	logic                          fits;
	logic [sazoh_pkg::OPND_W-1:0]  rem_nxt;

	always_comb begin
		trial   = {rem_q, 1'b0};
		fits    = trial >= {1'b0, den_q};
		rem_nxt = fits ? sazoh_pkg::OPND_W'(trial - {1'b0, den_q})
		               : trial[sazoh_pkg::OPND_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[FRAC_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

[sv/sazoh_dp.sv]
// Datapath of the steering actuator: state registers, shared multiplier,
// accumulators, saturation, clamp and the output word register.
// Depends on sazoh_pkg and sazoh_div.
module sazoh_dp #(
	parameter int FRAC_BITS = sazoh_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sazoh_pkg::cfg_t                  cfg,
	input  sazoh_pkg::cmd_t                  cmd,
	output sazoh_pkg::sts_t                  sts,
	input  logic signed [sazoh_pkg::WORD_W-1:0] angle_request,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic signed [sazoh_pkg::WORD_W-1:0] angle_out,
	output logic signed [sazoh_pkg::WORD_W-1:0] rate_out,
	output logic [1:0]                       branch,
	output logic                             angle_clamped
);

	localparam int W  = sazoh_pkg::WORD_W;
	localparam int OW = sazoh_pkg::OPND_W;
	localparam int PW = sazoh_pkg::PROD_W;
	localparam int ACC_W = PW - FRAC_BITS + 2;
	localparam logic [OW-1:0] ONE_Q = OW'(1) << FRAC_BITS;
	localparam logic signed [ACC_W-1:0] MIN_EXT = ACC_W'(sazoh_pkg::ANGLE_MIN_CODE);
	localparam logic signed [ACC_W-1:0] MAX_EXT = ACC_W'(sazoh_pkg::ANGLE_MAX_CODE);
	localparam logic signed [W-1:0] SAT_MIN = 32'sh8000_0000;
	localparam logic signed [W-1:0] SAT_MAX = 32'sh7FFF_FFFF;

	logic signed [W-1:0]     req_q;
	logic signed [W-1:0]     ang_q;
	logic signed [W-1:0]     rate_q;
	logic signed [W-1:0]     ex_a_q;
	logic signed [W-1:0]     ex_r_q;
	logic signed [OW-1:0]    op_a;
	logic signed [OW-1:0]    op_b;
	logic signed [PW-1:0]    prod_s1;
	logic signed [ACC_W-1:0] acc_a_q;
	logic signed [ACC_W-1:0] acc_r_q;
	logic signed [ACC_W-1:0] sh_f;
	logic signed [ACC_W-1:0] sh_f1;
	logic [sazoh_pkg::LIM_W-1:0] t_acc_q;
	logic [sazoh_pkg::LIM_W-1:0] t_con_q;
	sazoh_pkg::br_t          br_q;
	logic [OW-1:0]           abs_r0;
	logic [OW-1:0]           abs_exr;
	logic [OW-1:0]           lim_ext;
	logic [OW-1:0]           lim_sgn;
	logic [OW-1:0]           div_num;
	logic [OW-1:0]           div_den;
	logic                    pos;
	logic [FRAC_BITS-1:0]    quo;
	logic                    div_done;
	logic signed [W-1:0]     new_rate;
	logic signed [W-1:0]     clamp_angle;
	logic                    clamp_hit;
	logic                    out_valid_q;
	logic signed [W-1:0]     angle_out_q;
	logic signed [W-1:0]     rate_out_q;
	logic [1:0]              branch_q;
	logic                    clamped_q;

	function automatic logic signed [W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-W:0] hi;
		hi = v[ACC_W-1:W-1];
		if ((&hi) || !(|hi))
			return v[W-1:0];
		return v[ACC_W-1] ? SAT_MIN : SAT_MAX;
	endfunction

	// Magnitudes, the signed limit, divider operands, new rate and shifts.
	always_comb begin
		abs_r0  = rate_q[W-1] ? (OW'(0) - sazoh_pkg::sext33(rate_q))
		                      : sazoh_pkg::sext33(rate_q);
		abs_exr = ex_r_q[W-1] ? (OW'(0) - sazoh_pkg::sext33(ex_r_q))
		                      : sazoh_pkg::sext33(ex_r_q);
		lim_ext = {2'b00, cfg.rate_limit};
		pos     = !ex_r_q[W-1] && (ex_r_q != '0);
		lim_sgn = pos ? lim_ext : (OW'(0) - lim_ext);
		div_num = lim_ext - abs_r0;
		div_den = abs_exr - abs_r0;
		new_rate = (br_q == sazoh_pkg::BR_EXACT) ? ex_r_q : $signed(lim_sgn[W-1:0]);
		sh_f  = ACC_W'(prod_s1 >>> FRAC_BITS);
		sh_f1 = ACC_W'(prod_s1 >>> (FRAC_BITS + 1));
	end

	always_comb begin
		clamp_hit   = 1'b0;
		clamp_angle = acc_a_q[W-1:0];
		if (acc_a_q < MIN_EXT) begin
			clamp_hit   = 1'b1;
			clamp_angle = sazoh_pkg::ANGLE_MIN_CODE;
		end else if (acc_a_q > MAX_EXT) begin
			clamp_hit   = 1'b1;
			clamp_angle = sazoh_pkg::ANGLE_MAX_CODE;
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.mul_sel)
			sazoh_pkg::MS_A00_ANG: begin
				op_a = $signed(sazoh_pkg::sext33(cfg.a00));
				op_b = $signed(sazoh_pkg::sext33(ang_q));
			end
			sazoh_pkg::MS_A01_RATE: begin
				op_a = $signed(sazoh_pkg::sext33(cfg.a01));
				op_b = $signed(sazoh_pkg::sext33(rate_q));
			end
			sazoh_pkg::MS_B0_REQ: begin
				op_a = $signed(sazoh_pkg::sext33(cfg.b0));
				op_b = $signed(sazoh_pkg::sext33(req_q));
			end
			sazoh_pkg::MS_A10_ANG: begin
				op_a = $signed(sazoh_pkg::sext33(cfg.a10));
				op_b = $signed(sazoh_pkg::sext33(ang_q));
			end
			sazoh_pkg::MS_A11_RATE: begin
				op_a = $signed(sazoh_pkg::sext33(cfg.a11));
				op_b = $signed(sazoh_pkg::sext33(rate_q));
			end
			sazoh_pkg::MS_B1_REQ: begin
				op_a = $signed(sazoh_pkg::sext33(cfg.b1));
				op_b = $signed(sazoh_pkg::sext33(req_q));
			end
			sazoh_pkg::MS_RATE_DT: begin
				op_a = $signed(lim_sgn);
				op_b = $signed({2'b00, cfg.step_time});
			end
			sazoh_pkg::MS_FRAC_DT: begin
				op_a = $signed(OW'(quo));
				op_b = $signed({2'b00, cfg.step_time});
			end
			sazoh_pkg::MS_OMF_DT: begin
				op_a = $signed(ONE_Q - OW'(quo));
				op_b = $signed({2'b00, cfg.step_time});
			end
			sazoh_pkg::MS_SUM_TACC: begin
				op_a = $signed(abs_r0 + lim_ext);
				op_b = $signed({2'b00, t_acc_q});
			end
			sazoh_pkg::MS_LIM_TCON: begin
				op_a = $signed(lim_ext);
				op_b = $signed({2'b00, t_con_q});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	sazoh_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (quo)
	);

	always_comb begin
		sts.rate_ok  = abs_exr <= lim_ext;
		sts.rate_sat = abs_r0 >= lim_ext;
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || !out_stall;
	end

	// Actuator state and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q       <= '0;
			rate_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				ang_q       <= clamp_angle;
				rate_q      <= new_rate;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			req_q <= angle_request;
		if (cmd.mul_en)
			prod_s1 <= op_a * op_b;
		if (cmd.sat_en) begin
			ex_a_q <= sat32(acc_a_q);
			ex_r_q <= sat32(acc_r_q);
		end
		if (cmd.br_en)
			br_q <= cmd.br_val;
		unique case (cmd.acc_op)
			sazoh_pkg::ACC_NONE: ;
			sazoh_pkg::ACC_CLR: begin
				acc_a_q <= '0;
				acc_r_q <= '0;
			end
			sazoh_pkg::ACC_ROW_A:     acc_a_q <= acc_a_q + sh_f;
			sazoh_pkg::ACC_ROW_R:     acc_r_q <= acc_r_q + sh_f;
			sazoh_pkg::ACC_ANG_INIT:  acc_a_q <= ACC_W'(ang_q);
			sazoh_pkg::ACC_ANG_EXACT: acc_a_q <= ACC_W'(ex_a_q);
			sazoh_pkg::ACC_ANG_PIN:   acc_a_q <= ACC_W'(ang_q) + sh_f;
			sazoh_pkg::ACC_ANG_DACC:  acc_a_q <= pos ? acc_a_q + sh_f1 : acc_a_q - sh_f1;
			sazoh_pkg::ACC_ANG_DCON:  acc_a_q <= pos ? acc_a_q + sh_f : acc_a_q - sh_f;
			sazoh_pkg::ACC_CAP_TACC:  t_acc_q <= sh_f[sazoh_pkg::LIM_W-1:0];
			sazoh_pkg::ACC_CAP_TCON:  t_con_q <= sh_f[sazoh_pkg::LIM_W-1:0];
			default: ;
		endcase
		if (cmd.finish) begin
			angle_out_q <= clamp_angle;
			rate_out_q  <= new_rate;
			branch_q    <= br_q;
			clamped_q   <= clamp_hit;
		end
	end

	assign out_valid     = out_valid_q;
	assign angle_out     = angle_out_q;
	assign rate_out      = rate_out_q;
	assign branch        = branch_q;
	assign angle_clamped = clamped_q;

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ang_q >= sazoh_pkg::ANGLE_MIN_CODE) && (ang_q <= sazoh_pkg::ANGLE_MAX_CODE))
		else $error("stored steering angle left the clamp range");

	a_word_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("output word appeared without a finish command");

endmodule

[sv/sazoh_ctrl.sv]
// Controller of the steering actuator: sequences the multiplier, the
// divider and the accumulators, one input word at a time.
// Depends on sazoh_pkg.
module sazoh_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  sazoh_pkg::sts_t sts,
	output sazoh_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROW,
		S_SAT,
		S_CLASS,
		S_PIN,
		S_DIV,
		S_MID,
		S_FIN
	} state_t;

	localparam logic [2:0] ROW_LAST   = 3'd6;
	localparam logic [2:0] ROW_A_LAST = 3'd3;
	localparam logic [2:0] MID_FRAC   = 3'd0;
	localparam logic [2:0] MID_OMF    = 3'd1;
	localparam logic [2:0] MID_SUM    = 3'd2;
	localparam logic [2:0] MID_LIM    = 3'd3;
	localparam logic [2:0] MID_LAST   = 3'd4;

	state_t     state_q;
	logic [2:0] step_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.mul_sel = sazoh_pkg::MS_A00_ANG;
		cmd.acc_op  = sazoh_pkg::ACC_NONE;
		cmd.br_val  = sazoh_pkg::BR_EXACT;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid)
					cmd.acc_op = sazoh_pkg::ACC_CLR;
			end
			S_ROW: begin
				// Products are issued one step ahead of their accumulation.
				cmd.mul_en = (step_q != ROW_LAST);
				unique case (step_q)
					3'd0:    cmd.mul_sel = sazoh_pkg::MS_A00_ANG;
					3'd1:    cmd.mul_sel = sazoh_pkg::MS_A01_RATE;
					3'd2:    cmd.mul_sel = sazoh_pkg::MS_B0_REQ;
					3'd3:    cmd.mul_sel = sazoh_pkg::MS_A10_ANG;
					3'd4:    cmd.mul_sel = sazoh_pkg::MS_A11_RATE;
					default: cmd.mul_sel = sazoh_pkg::MS_B1_REQ;
				endcase
				if (step_q == '0)
					cmd.acc_op = sazoh_pkg::ACC_NONE;
				else if (step_q <= ROW_A_LAST)
					cmd.acc_op = sazoh_pkg::ACC_ROW_A;
				else
					cmd.acc_op = sazoh_pkg::ACC_ROW_R;
			end
			S_SAT: cmd.sat_en = 1'b1;
			S_CLASS: begin
				cmd.br_en = 1'b1;
				if (sts.rate_ok) begin
					cmd.br_val = sazoh_pkg::BR_EXACT;
					cmd.acc_op = sazoh_pkg::ACC_ANG_EXACT;
				end else if (sts.rate_sat) begin
					cmd.br_val  = sazoh_pkg::BR_PINNED;
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = sazoh_pkg::MS_RATE_DT;
				end else begin
					cmd.br_val    = sazoh_pkg::BR_MIDSTEP;
					cmd.div_start = 1'b1;
					cmd.acc_op    = sazoh_pkg::ACC_ANG_INIT;
				end
			end
			S_PIN: cmd.acc_op = sazoh_pkg::ACC_ANG_PIN;
			S_DIV: ;
			S_MID: begin
				unique case (step_q)
					MID_FRAC: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = sazoh_pkg::MS_FRAC_DT;
					end
					MID_OMF: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = sazoh_pkg::MS_OMF_DT;
						cmd.acc_op  = sazoh_pkg::ACC_CAP_TACC;
					end
					MID_SUM: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = sazoh_pkg::MS_SUM_TACC;
						cmd.acc_op  = sazoh_pkg::ACC_CAP_TCON;
					end
					MID_LIM: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = sazoh_pkg::MS_LIM_TCON;
						cmd.acc_op  = sazoh_pkg::ACC_ANG_DACC;
					end
					default: cmd.acc_op = sazoh_pkg::ACC_ANG_DCON;
				endcase
			end
			S_FIN: cmd.finish = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ROW;
						step_q  <= '0;
					end
				end
				S_ROW: begin
					if (step_q == ROW_LAST)
						state_q <= S_SAT;
					else
						step_q <= step_q + 3'd1;
				end
				S_SAT: state_q <= S_CLASS;
				S_CLASS: begin
					if (sts.rate_ok)
						state_q <= S_FIN;
					else if (sts.rate_sat)
						state_q <= S_PIN;
					else
						state_q <= S_DIV;
				end
				S_PIN: state_q <= S_FIN;
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_MID;
						step_q  <= '0;
					end
				end
				S_MID: begin
					if (step_q == MID_LAST)
						state_q <= S_FIN;
					else
						step_q <= step_q + 3'd1;
				end
				S_FIN: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIV)
		else $error("divider finished while the controller was not waiting");

	a_mid_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MID && step_q == MID_FRAC) |-> $past(sts.div_done))
		else $error("mid-step products started before the fraction was ready");

endmodule

[sv/steering_actuator_zoh_rate_limited.sv]
// Each accepted word takes the row products on the single shared 33x33 multiplier,
// saturation and classification; the pinned branch adds one product and the mid-step
// branch the bit-serial divider and its own products. Words are Q8.24 at the default
// FRAC_BITS. The result waits for a free output word register, and the input stays
// stalled until it is loaded, so one word is in work at a time. Reset (async, active low)
// clears the angle and rate to zero and loads the configuration register defaults.
module steering_actuator_zoh_rate_limited #(
	parameter int FRAC_BITS = sazoh_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [sazoh_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [sazoh_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic signed [sazoh_pkg::WORD_W-1:0]     angle_request,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [sazoh_pkg::WORD_W-1:0]     angle_out,
	output logic signed [sazoh_pkg::WORD_W-1:0]     rate_out,
	output logic [1:0]                              branch,
	output logic                                    angle_clamped
);

	// The block evaluates one discrete zero-order-hold step of a second-order
	// steering model per input word. Six products of the state matrix row sums
	// run back to back through one multiplier, then the rate is compared with the
	// limit. When the new rate would exceed the limit, either the rate is pinned
	// and the angle moves linearly, or a divider finds the share of the step spent
	// accelerating and the angle follows a trapezoid then a constant-rate ramp.

	sazoh_pkg::cfg_t cfg_q;
	sazoh_pkg::cmd_t cmd;
	sazoh_pkg::sts_t sts;

	// Configuration registers. Writes must come only while the block is idle, which the user
	// must ensure and the block does not enforce; the datapath reads them directly, no shadow copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a00        <= sazoh_pkg::RST_COEF_ONE;
			cfg_q.a01        <= sazoh_pkg::RST_COEF_ZERO;
			cfg_q.a10        <= sazoh_pkg::RST_COEF_ZERO;
			cfg_q.a11        <= sazoh_pkg::RST_COEF_ONE;
			cfg_q.b0         <= sazoh_pkg::RST_COEF_ZERO;
			cfg_q.b1         <= sazoh_pkg::RST_COEF_ZERO;
			cfg_q.rate_limit <= sazoh_pkg::RST_LIMIT;
			cfg_q.step_time  <= sazoh_pkg::RST_STEP;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sazoh_pkg::CFG_A00:   cfg_q.a00 <= cfg_data;
				sazoh_pkg::CFG_A01:   cfg_q.a01 <= cfg_data;
				sazoh_pkg::CFG_A10:   cfg_q.a10 <= cfg_data;
				sazoh_pkg::CFG_A11:   cfg_q.a11 <= cfg_data;
				sazoh_pkg::CFG_B0:    cfg_q.b0  <= cfg_data;
				sazoh_pkg::CFG_B1:    cfg_q.b1  <= cfg_data;
				sazoh_pkg::CFG_LIMIT: cfg_q.rate_limit <= cfg_data[sazoh_pkg::LIM_W-1:0];
				sazoh_pkg::CFG_STEP:  cfg_q.step_time  <= cfg_data[sazoh_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// The controller holds the input stalled from acceptance until the result
	// word is loaded into the output register; the output register lets a new
	// word be accepted while the previous result still waits to be taken.
	sazoh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	sazoh_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.angle_request(angle_request),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.angle_out    (angle_out),
		.rate_out     (rate_out),
		.branch       (branch),
		.angle_clamped(angle_clamped)
	);

endmodule

[sim/steering_actuator_zoh_rate_limited_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the rate-limited steering actuator: directed and random
// angle requests under many register settings, with every output word predicted in-line.
// Depends on sazoh_pkg and the steering_actuator_zoh_rate_limited top level.
module steering_actuator_zoh_rate_limited_test;

	// The predictor works at the block's default fraction width.
	localparam int FRAC        = sazoh_pkg::FRAC_BITS_DEF;
	// The cycle limit allows for the slowest words with long input gaps and output stalls,
	// and is many times the slowest correct run of ~430 words.
	localparam int CYCLE_LIMIT = 600000;

	// One predicted output word.
	typedef struct {
		logic signed [sazoh_pkg::WORD_W-1:0] angle;
		logic signed [sazoh_pkg::WORD_W-1:0] rate;
		sazoh_pkg::br_t                      br;
		logic                                clamped;
	} steer_word_t;

	// Every input of the block starts at a known value.
	logic                                clk           = 1'b0;
	logic                                arst_n        = 1'b0;
	logic                                cfg_we        = 1'b0;
	logic [sazoh_pkg::CFG_IDX_W-1:0]     cfg_idx       = '0;
	logic [sazoh_pkg::CFG_DATA_W-1:0]    cfg_data      = '0;
	logic                                in_valid      = 1'b0;
	logic                                in_stall;
	logic signed [sazoh_pkg::WORD_W-1:0] angle_request = '0;
	logic                                out_valid;
	logic                                out_stall     = 1'b0;
	logic signed [sazoh_pkg::WORD_W-1:0] angle_out;
	logic signed [sazoh_pkg::WORD_W-1:0] rate_out;
	logic [1:0]                          branch;
	logic                                angle_clamped;

	// Predictor copy of the register file and the actuator state.
	sazoh_pkg::cfg_t cfg_q;
	longint          steer_angle_q;
	longint          steer_rate_q;

	// Words accepted on the input whose results have not come out yet, oldest first.
	steer_word_t pending_words[$];

	int mismatches    = 0;
	int words_checked = 0;
	int n_exact       = 0;
	int n_pinned      = 0;
	int n_midstep     = 0;
	int n_clamped     = 0;
	int n_settings    = 0;
	int in_gap_pct    = 0;
	int out_stall_pct = 0;
	int stall_left    = 0;
	int cycles        = 0;

	steering_actuator_zoh_rate_limited u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.angle_request (angle_request),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.angle_out     (angle_out),
		.rate_out      (rate_out),
		.branch        (branch),
		.angle_clamped (angle_clamped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d words outstanding", cycles,
				pending_words.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Fixed-point helpers of the predictor
	// ------------------------------------------------------------------

	// Exact product, then floor toward minus infinity (arithmetic shift).
	function automatic longint qmul(input longint a, input longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Most gaps are short, about one in ten is long; pct is the chance that one starts.
	function automatic int pick_idle(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 10);
		return $urandom_range(3, 1);
	endfunction

	function automatic int pick_level();
		case ($urandom_range(2))
			0: return 10;
			1: return 30;
			default: return 60;
		endcase
	endfunction

	task automatic reset_model();
		cfg_q.a00        = sazoh_pkg::RST_COEF_ONE;
		cfg_q.a01        = sazoh_pkg::RST_COEF_ZERO;
		cfg_q.a10        = sazoh_pkg::RST_COEF_ZERO;
		cfg_q.a11        = sazoh_pkg::RST_COEF_ONE;
		cfg_q.b0         = sazoh_pkg::RST_COEF_ZERO;
		cfg_q.b1         = sazoh_pkg::RST_COEF_ZERO;
		cfg_q.rate_limit = sazoh_pkg::RST_LIMIT;
		cfg_q.step_time  = sazoh_pkg::RST_STEP;
		steer_angle_q    = 0;
		steer_rate_q     = 0;
	endtask

	// Advances the predicted actuator by one tick and returns the word the block owes.
	// The exact step comes from the 2x2 matrix and input vector. A rate beyond the limit
	// either stays pinned (the old rate was already at the limit) or is reached part-way
	// through the tick, in which case the angle covers a trapezoid while accelerating
	// and then moves at the limit rate for the rest of the tick.
	function automatic steer_word_t step_actuator(
		input logic signed [sazoh_pkg::WORD_W-1:0] req);
		longint            a0, r0, lim, dt, ex_a, ex_r, new_a, new_r, ar0, travel;
		longint unsigned   num, den, frac, t_acc, t_con, d_acc, d_con;
		steer_word_t       w;
		a0  = steer_angle_q;
		r0  = steer_rate_q;
		lim = longint'(cfg_q.rate_limit);
		dt  = longint'(cfg_q.step_time);

		ex_a = clip32(qmul($signed(cfg_q.a00), a0) + qmul($signed(cfg_q.a01), r0) +
			qmul($signed(cfg_q.b0), req));
		ex_r = clip32(qmul($signed(cfg_q.a10), a0) + qmul($signed(cfg_q.a11), r0) +
			qmul($signed(cfg_q.b1), req));

		if (mag(ex_r) <= lim) begin
			new_a = ex_a;
			new_r = ex_r;
			w.br  = sazoh_pkg::BR_EXACT;
		end else begin
			// A zero limit lands here for any nonzero rate and pins the rate at zero.
			new_r = (ex_r > 0) ? lim : -lim;
			ar0   = mag(r0);
			if (ar0 >= lim) begin
				new_a = a0 + qmul(new_r, dt);
				w.br  = sazoh_pkg::BR_PINNED;
			end else begin
				// Fraction of the tick spent accelerating; always below one.
				num    = longint'(lim - ar0) << FRAC;
				den    = longint'(mag(ex_r) - ar0);
				frac   = num / den;
				t_acc  = (frac * dt) >> FRAC;
				t_con  = (((64'd1 << FRAC) - frac) * dt) >> FRAC;
				d_acc  = ((ar0 + lim) * t_acc) >> (FRAC + 1);
				d_con  = (lim * t_con) >> FRAC;
				travel = longint'(d_acc + d_con);
				new_a  = (ex_r > 0) ? a0 + travel : a0 - travel;
				w.br   = sazoh_pkg::BR_MIDSTEP;
			end
		end

		// The unclamped angle is wide, so the clamp also acts as saturation.
		w.clamped = 1'b0;
		if (new_a < longint'(sazoh_pkg::ANGLE_MIN_CODE)) begin
			new_a     = longint'(sazoh_pkg::ANGLE_MIN_CODE);
			w.clamped = 1'b1;
		end else if (new_a > longint'(sazoh_pkg::ANGLE_MAX_CODE)) begin
			new_a     = longint'(sazoh_pkg::ANGLE_MAX_CODE);
			w.clamped = 1'b1;
		end

		steer_angle_q = new_a;
		steer_rate_q  = new_r;
		w.angle       = new_a[sazoh_pkg::WORD_W-1:0];
		w.rate        = new_r[sazoh_pkg::WORD_W-1:0];
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Output side: random stall and in-order checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch at word %0d, %s: got %0d, expected %0d", words_checked, what,
			got, want);
	endtask

	task automatic check_word();
		steer_word_t want;
		if (pending_words.size() == 0) begin
			report_mismatch("word with none outstanding", angle_out, 0);
			return;
		end
		want = pending_words.pop_front();
		if (angle_out !== want.angle)
			report_mismatch("angle_out", angle_out, want.angle);
		if (rate_out !== want.rate)
			report_mismatch("rate_out", rate_out, want.rate);
		if (branch !== want.br)
			report_mismatch("branch", branch, want.br);
		if (angle_clamped !== want.clamped)
			report_mismatch("angle_clamped", angle_clamped, want.clamped);
		words_checked++;
	endtask

	// Values read here are those before the edge, so a word counts as taken exactly when
	// the block sees valid high and stall low. The stall for the next cycle is then
	// chosen without looking at out_valid.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_word();
		if (stall_left > 0)
			stall_left--;
		else
			stall_left = pick_idle(out_stall_pct);
		out_stall <= (stall_left > 0);
	end

	// ------------------------------------------------------------------
	// Input side and register writes
	// ------------------------------------------------------------------

	// Presents one request, after an optional random gap, and waits until it is taken.
	// The valid stays high on return so that the next request can follow back to back;
	// every caller either sends again or lowers it in the same time step.
	task automatic send_request(input logic signed [sazoh_pkg::WORD_W-1:0] req);
		int          gap;
		steer_word_t w;
		gap = pick_idle(in_gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		angle_request <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		w = step_actuator(req);
		case (w.br)
			sazoh_pkg::BR_EXACT:  n_exact++;
			sazoh_pkg::BR_PINNED: n_pinned++;
			default:              n_midstep++;
		endcase
		if (w.clamped)
			n_clamped++;
		pending_words = {pending_words, w};
	endtask

	// Stops sending and waits for every outstanding word, plus a short margin so the
	// block is surely back at rest.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Holds the write enable high across consecutive calls; apply_settings lowers it.
	task automatic write_reg(input logic [sazoh_pkg::CFG_IDX_W-1:0] idx,
		input logic [sazoh_pkg::CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Writes the whole register file once the block is idle. The unused top bit of the
	// two 31-bit registers gets random junk, which the block must drop.
	task automatic apply_settings(input sazoh_pkg::cfg_t c);
		wait_idle();
		write_reg(sazoh_pkg::CFG_A00, c.a00);
		write_reg(sazoh_pkg::CFG_A01, c.a01);
		write_reg(sazoh_pkg::CFG_A10, c.a10);
		write_reg(sazoh_pkg::CFG_A11, c.a11);
		write_reg(sazoh_pkg::CFG_B0, c.b0);
		write_reg(sazoh_pkg::CFG_B1, c.b1);
		write_reg(sazoh_pkg::CFG_LIMIT, {1'($urandom_range(1)), c.rate_limit});
		write_reg(sazoh_pkg::CFG_STEP, {1'($urandom_range(1)), c.step_time});
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_q = c;
		n_settings++;
	endtask

	// A plausible damped servo: angle integrates the rate, the rate is pulled toward
	// the request. Limits and gains vary so that all three branches come up.
	function automatic sazoh_pkg::cfg_t servo_settings();
		sazoh_pkg::cfg_t c;
		int unsigned     k;
		k            = $urandom_range(16777216, 1048576);
		c.step_time  = 31'($urandom_range(1677721, 16777));
		c.a00        = sazoh_pkg::RST_COEF_ONE;
		c.a01        = {1'b0, c.step_time};
		c.a10        = -k;
		c.a11        = sazoh_pkg::RST_COEF_ONE - $urandom_range(8388608);
		c.b0         = ($urandom_range(3) == 0) ? $urandom_range(8388608) : 0;
		c.b1         = k;
		c.rate_limit = 31'($urandom_range(67108864, 1048576));
		return c;
	endfunction

	// Arbitrary register contents, for saturation and full bit coverage.
	function automatic sazoh_pkg::cfg_t wild_settings();
		sazoh_pkg::cfg_t c;
		c.a00        = $urandom();
		c.a01        = $urandom();
		c.a10        = $urandom();
		c.a11        = $urandom();
		c.b0         = $urandom();
		c.b1         = $urandom();
		c.rate_limit = $urandom_range(1) ? 31'($urandom_range(31'h7FFFFFFF, 1)) :
			31'($urandom_range(65535, 1));
		c.step_time  = $urandom_range(1) ? 31'($urandom_range(31'h7FFFFFFF, 1)) :
			31'($urandom_range(65535, 1));
		return c;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Right after reset, with the default registers, the state must stay at zero for
	// any request, including the extremes of the field.
	task automatic test_reset_state();
		in_gap_pct    = 20;
		out_stall_pct = 20;
		send_request(32'sd0);
		send_request(32'h7FFFFFFF);
		send_request(32'h80000000);
		send_request(-32'sd1);
	endtask

	// A slow servo with a tight rate limit walks through each branch in turn: entering
	// the limit mid-step, staying pinned, pinned with the sign flipped, then exact steps
	// as the rate decays. A zero limit then pins the rate at zero.
	task automatic test_branch_cases();
		sazoh_pkg::cfg_t c;
		c.a00        = sazoh_pkg::RST_COEF_ONE;
		c.a01        = 32'sd167772;
		c.a10        = -32'sd16777216;
		c.a11        = 32'sd13421773;
		c.b0         = sazoh_pkg::RST_COEF_ZERO;
		c.b1         = sazoh_pkg::RST_COEF_ONE;
		c.rate_limit = 31'd1677722;
		c.step_time  = sazoh_pkg::RST_STEP;
		apply_settings(c);
		send_request(32'sd3355443);
		send_request(32'sd3355443);
		send_request(-32'sd3355443);
		send_request(32'sd0);
		send_request(32'sd0);
		c.rate_limit = '0;
		apply_settings(c);
		send_request(32'sd3355443);
		send_request(32'sd0);
	endtask

	// Angle clamping at both ends, then the register extremes, where the row sums
	// saturate and the limit and step time sit at their largest and smallest.
	task automatic test_limits_and_saturation();
		sazoh_pkg::cfg_t c;
		c.a00        = sazoh_pkg::RST_COEF_ONE;
		c.a01        = sazoh_pkg::RST_COEF_ZERO;
		c.a10        = sazoh_pkg::RST_COEF_ZERO;
		c.a11        = sazoh_pkg::RST_COEF_ONE;
		c.b0         = sazoh_pkg::RST_COEF_ONE;
		c.b1         = sazoh_pkg::RST_COEF_ZERO;
		c.rate_limit = 31'h7FFFFFFF;
		c.step_time  = sazoh_pkg::RST_STEP;
		apply_settings(c);
		send_request(32'sd6710886);
		send_request(32'sd1);
		send_request(-32'sd16777216);

		c.a00        = 32'h7FFFFFFF;
		c.a01        = 32'h7FFFFFFF;
		c.a10        = 32'h7FFFFFFF;
		c.a11        = 32'h7FFFFFFF;
		c.b0         = 32'h7FFFFFFF;
		c.b1         = 32'h7FFFFFFF;
		c.rate_limit = 31'h7FFFFFFF;
		c.step_time  = 31'h7FFFFFFF;
		apply_settings(c);
		send_request(32'h7FFFFFFF);
		send_request(32'h80000000);
		send_request(32'h7FFFFFFF);

		c.a00        = 32'h80000000;
		c.a01        = 32'h80000000;
		c.a10        = 32'h80000000;
		c.a11        = 32'h80000000;
		c.b0         = 32'h80000000;
		c.b1         = 32'h80000000;
		c.rate_limit = 31'd1;
		c.step_time  = 31'd1;
		apply_settings(c);
		send_request(32'h7FFFFFFF);
		send_request(-32'sd1);
		send_request(32'h80000000);
	endtask

	// Back-to-back bursts with the sender holding off in between until every word has
	// come out, so the block drains completely in the middle of a setting.
	task automatic test_drain_pause();
		apply_settings(servo_settings());
		in_gap_pct    = 0;
		out_stall_pct = 30;
		repeat (12)
			send_request($urandom_range(16777216) - 8388608);
		wait_idle();
		repeat (12)
			send_request($urandom_range(16777216) - 8388608);
	endtask

	// Random phases, each with its own registers and idle levels. Requests come as held steps,
	// as a controller would send them, mostly within +/-0.5, a little past the +/-0.4 steering
	// range; a few are full-width noise or field extremes. The first phase has no idling.
	task automatic test_random_traffic();
		logic signed [sazoh_pkg::WORD_W-1:0] target;
		int                                  hold;
		for (int p = 0; p < 8; p++) begin
			apply_settings((p % 3 == 2) ? wild_settings() : servo_settings());
			in_gap_pct    = (p == 0) ? 0 : pick_level();
			out_stall_pct = (p == 0) ? 0 : pick_level();
			hold          = 0;
			for (int i = 0; i < 48; i++) begin
				if (hold == 0) begin
					hold = $urandom_range(8, 1);
					case ($urandom_range(9))
						0: target = $urandom();
						1: target = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
						default: target = $urandom_range(16777216) - 8388608;
					endcase
				end
				hold--;
				send_request(target);
			end
		end
	endtask

	initial begin
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_branch_cases();
		test_limits_and_saturation();
		test_drain_pause();
		test_random_traffic();

		// Let every outstanding word arrive, then watch a while longer for strays.
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		$display("Checked %0d words under %0d register settings.", words_checked, n_settings);
		$display("Branches: %0d exact, %0d pinned, %0d mid-step; %0d angles clamped.",
			n_exact, n_pinned, n_midstep, n_clamped);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[sim.f]
sv/sazoh_pkg.sv
sv/sazoh_div.sv
sv/sazoh_dp.sv
sv/sazoh_ctrl.sv
sv/steering_actuator_zoh_rate_limited.sv
sim/steering_actuator_zoh_rate_limited_test.sv
